// ===== rtl/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadline timer table package
// Shared constants, operation and status codes, and controller types.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam int unsigned TimerSlots = 16;
  localparam int unsigned SlotW      = $clog2(TimerSlots);
  localparam logic [31:0] WindowReset = 32'd3600000;
  localparam logic [63:0] AllOnes     = '1;
  localparam logic [1:0]  WindowAddr  = 2'd0;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_REFRESH = 3'd2,
    OP_RESET   = 3'd3,
    OP_QUERY   = 3'd4,
    OP_COLLECT = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EMIT,
    S_WAIT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the request
    logic scan_clear; // start a scan
    logic scan_step;  // examine one slot
    logic out_load;   // commit the request and load the output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
    logic emit_more;  // collect: another due slot remains after this one
    logic multi;      // request may give several results
  } stat_t;

endpackage

// ===== rtl/dtt_datapath.sv =====
// ----------------------------------------------------------------------------
// Deadline timer table datapath
// Timer stores, one-slot-a-cycle scan unit and the result register.
// ----------------------------------------------------------------------------
module dtt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  dtt_pkg::cmd_t                 cmd,
  output dtt_pkg::stat_t                stat,
  input  logic [2:0]                    op,
  input  logic [63:0]                   now_ms,
  input  logic [3:0]                    target_slot,
  input  logic [31:0]                   period_ms,
  input  logic                          repeats,
  input  logic                          restart_now,
  input  logic [31:0]                   window,
  output logic [1:0]                    status,
  output logic [3:0]                    slot_index,
  output logic [63:0]                   wait_ms,
  output logic                          front_alert,
  output logic                          last_result
);

  localparam int unsigned N = dtt_pkg::TimerSlots;
  localparam int unsigned SW = dtt_pkg::SlotW;

  logic [63:0] deadline_store [N];
  logic [31:0] period_store [N];
  logic        repeat_store [N];
  logic [N-1:0] live_store;
  logic        front_flag;
  logic [63:0] prior_time;

  // Captured request.
  logic [2:0]  r_op;
  logic [63:0] r_now;
  logic [SW-1:0] r_tgt;
  logic [31:0] r_per;
  logic        r_rep;
  logic        r_fnow;

  // Scan unit.
  logic [SW-1:0] scan_idx;
  logic          best_ok;
  logic [SW-1:0] best;
  logic [63:0]   best_dl;
  logic          free_ok;
  logic [SW-1:0] free_slot;
  logic          roll;
  logic [N-1:0]  done_mask;   // slots already emitted in this collect
  logic          emitted_any;
  logic          more_due;    // a second due slot was seen in this pass

  logic cand, cand_better, due_i;
  logic [63:0] dl_i;

  always_comb begin
    dl_i  = deadline_store[scan_idx];
    due_i = live_store[scan_idx] && !done_mask[scan_idx] && (roll || dl_i <= r_now);
    if (r_op == dtt_pkg::OP_COLLECT) begin
      cand = due_i;
    end else begin
      cand = live_store[scan_idx];
    end
    // Scan runs in increasing slot order, so a strict compare keeps the lower slot on ties.
    cand_better = cand && (!best_ok || dl_i < best_dl);
  end

  assign stat.scan_done = (scan_idx == SW'(N - 1));
  assign stat.emit_more = best_ok && more_due;
  assign stat.multi     = (r_op == dtt_pkg::OP_COLLECT);

  // Values used when the request is committed.
  logic [63:0] start_v, sum_a, sum_b, sum_s;
  logic        sum_c;
  logic        tgt_live;
  logic        reset_noop;
  logic        front_now;

  always_comb begin
    tgt_live   = live_store[r_tgt];
    reset_noop = (r_per == period_store[r_tgt]) && !r_fnow;
    start_v    = r_fnow ? r_now : deadline_store[r_tgt] - 64'(period_store[r_tgt]);
    sum_a      = r_now;
    sum_b      = 64'(r_per);
    unique case (r_op)
      dtt_pkg::OP_REFRESH: sum_b = 64'(period_store[r_tgt]);
      dtt_pkg::OP_RESET:   sum_a = start_v;
      dtt_pkg::OP_COLLECT: sum_b = 64'(period_store[best]);
      default: ;
    endcase
    {sum_c, sum_s} = {1'b0, sum_a} + {1'b0, sum_b};
    if (sum_c) sum_s = dtt_pkg::AllOnes;
  end

  // Front check: the new deadline must precede every other live timer.
  // The scan result excludes nothing, so compare against the earliest other
  // deadline captured by an exclusion scan below.
  logic          oth_ok;
  logic [63:0]   oth_dl;
  logic [SW-1:0] oth;
  logic [SW-1:0] self_slot;

  always_comb begin
    self_slot = (r_op == dtt_pkg::OP_ADD) ? free_slot : r_tgt;
    front_now = !oth_ok || sum_s < oth_dl || (sum_s == oth_dl && self_slot < oth);
  end

  // Result of the request, loaded into the output register by out_load.
  logic [1:0]  status_next;
  logic [3:0]  slot_index_next;
  logic [63:0] wait_ms_next;
  logic        front_alert_next;
  logic        last_result_next;

  always_comb begin
    status_next      = dtt_pkg::ST_OK;
    slot_index_next  = '0;
    wait_ms_next     = '0;
    front_alert_next = 1'b0;
    last_result_next = 1'b1;
    unique case (r_op)
      dtt_pkg::OP_ADD: begin
        if (!free_ok) begin
          status_next = dtt_pkg::ST_FULL;
        end else begin
          slot_index_next  = 4'(free_slot);
          front_alert_next = front_now && !front_flag;
        end
      end
      dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH: begin
        slot_index_next = 4'(r_tgt);
        if (!tgt_live) status_next = dtt_pkg::ST_INACTIVE;
      end
      dtt_pkg::OP_RESET: begin
        slot_index_next = 4'(r_tgt);
        if (!reset_noop) begin
          if (!tgt_live) status_next = dtt_pkg::ST_INACTIVE;
          else front_alert_next = front_now && !front_flag;
        end
      end
      dtt_pkg::OP_QUERY: begin
        if (!best_ok) wait_ms_next = dtt_pkg::AllOnes;
        else if (r_now >= best_dl) wait_ms_next = '0;
        else wait_ms_next = best_dl - r_now;
      end
      dtt_pkg::OP_COLLECT: begin
        if (best_ok) begin
          slot_index_next  = 4'(best);
          last_result_next = !more_due;
        end else begin
          status_next = dtt_pkg::ST_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_store  <= '0;
      front_flag  <= 1'b0;
      prior_time  <= '0;
      last_result <= 1'b0;
    end else begin
      if (cmd.load) begin
        r_op   <= op;
        r_now  <= now_ms;
        r_tgt  <= SW'(target_slot);
        r_per  <= period_ms;
        r_rep  <= repeats;
        r_fnow <= restart_now;
        done_mask   <= '0;
        emitted_any <= 1'b0;
        roll        <= 1'b0;
      end
      if (cmd.scan_clear) begin
        scan_idx <= '0;
        best_ok  <= 1'b0;
        free_ok  <= 1'b0;
        oth_ok   <= 1'b0;
        more_due <= 1'b0;
        if (r_op == dtt_pkg::OP_COLLECT && !emitted_any) begin
          roll <= (r_now < prior_time) && (prior_time - r_now > 64'(window));
        end
      end
      if (cmd.scan_step) begin
        if (!stat.scan_done) scan_idx <= scan_idx + SW'(1);
        if (cand_better) begin
          best_ok <= 1'b1;
          best    <= scan_idx;
          best_dl <= dl_i;
        end
        if (cand && best_ok) more_due <= 1'b1;
        if (!live_store[scan_idx] && !free_ok) begin
          free_ok   <= 1'b1;
          free_slot <= scan_idx;
        end
        // A reset compares against every other live timer; an add takes a free
        // slot, so every live timer counts.
        if (live_store[scan_idx] && (r_op != dtt_pkg::OP_RESET || scan_idx != r_tgt) &&
            (!oth_ok || dl_i < oth_dl)) begin
          oth_ok <= 1'b1;
          oth    <= scan_idx;
          oth_dl <= dl_i;
        end
      end
      if (cmd.out_load) begin
        status      <= status_next;
        slot_index  <= slot_index_next;
        wait_ms     <= wait_ms_next;
        front_alert <= front_alert_next;
        last_result <= last_result_next;
        unique case (r_op)
          dtt_pkg::OP_ADD: begin
            if (free_ok) begin
              deadline_store[free_slot] <= sum_s;
              period_store[free_slot]   <= r_per;
              repeat_store[free_slot]   <= r_rep;
              live_store[free_slot]     <= 1'b1;
              if (front_alert_next) front_flag <= 1'b1;
            end
          end
          dtt_pkg::OP_CANCEL: begin
            if (tgt_live) live_store[r_tgt] <= 1'b0;
          end
          dtt_pkg::OP_REFRESH: begin
            if (tgt_live) deadline_store[r_tgt] <= sum_s;
          end
          dtt_pkg::OP_RESET: begin
            if (!reset_noop && tgt_live) begin
              period_store[r_tgt]   <= r_per;
              deadline_store[r_tgt] <= sum_s;
              if (front_alert_next) front_flag <= 1'b1;
            end
          end
          dtt_pkg::OP_QUERY: begin
            front_flag <= 1'b0;
          end
          dtt_pkg::OP_COLLECT: begin
            if (!emitted_any && live_store != '0) prior_time <= r_now;
            if (best_ok) begin
              emitted_any <= 1'b1;
              done_mask[best] <= 1'b1;
              if (repeat_store[best]) deadline_store[best] <= sum_s;
              else live_store[best] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/dtt_control.sv =====
// ----------------------------------------------------------------------------
// Deadline timer table controller
// Sequences capture, slot scans and result hand-off.
// ----------------------------------------------------------------------------
module dtt_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output dtt_pkg::cmd_t  cmd,
  input  dtt_pkg::stat_t stat
);

  dtt_pkg::state_t state, state_next;
  logic ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtt_pkg::S_IDLE;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      ov    <= ov_next;
    end
  end

  assign out_valid = ov;

  always_comb begin
    state_next = state;
    ov_next    = ov && out_stall;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      dtt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = dtt_pkg::S_SCAN;
        end
      end
      dtt_pkg::S_SCAN: begin
        cmd.scan_clear = 1'b1;
        state_next     = dtt_pkg::S_DECIDE;
      end
      dtt_pkg::S_DECIDE: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = dtt_pkg::S_EMIT;
      end
      dtt_pkg::S_EMIT: begin
        // The result register must be free before it is loaded again.
        if (!ov || !out_stall) begin
          cmd.out_load = 1'b1;
          ov_next      = 1'b1;
          if (stat.multi && stat.emit_more) state_next = dtt_pkg::S_SCAN;
          else state_next = dtt_pkg::S_IDLE;
        end
      end
      dtt_pkg::S_WAIT: state_next = dtt_pkg::S_IDLE;
      default: state_next = dtt_pkg::S_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == dtt_pkg::S_IDLE)
    else $error("load outside idle");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    state != dtt_pkg::S_IDLE |-> in_stall)
    else $error("input open while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

endmodule

// ===== rtl/deadline_timer_table.sv =====
// ----------------------------------------------------------------------------
// Deadline timer table
// Sixteen one-shot or recurring timers with add, cancel, refresh, reset,
// query and collect requests, scanned one slot per cycle.
// ----------------------------------------------------------------------------
// Sequence: after the accepting edge come scan set-up, sixteen scan steps and the
// result load; the next request is taken once the block is back in idle.
// Collect runs a further scan for each expired slot after the first, holding the
// input until the last result is loaded; a stalled result delays a load.
// Reset is synchronous: live bits, front flag, last collect time and window reset.
module deadline_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [63:0] now_ms,
  input  logic [3:0]  target_slot,
  input  logic [31:0] period_ms,
  input  logic        repeats,
  input  logic        restart_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  slot_index,
  output logic [63:0] wait_ms,
  output logic        front_alert,
  output logic        last_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dtt_pkg::cmd_t  cmd;
  dtt_pkg::stat_t stat;
  logic [31:0] rollover_window_ms;

  // The single register lies at address zero; other addresses read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      rollover_window_ms <= dtt_pkg::WindowReset;
    end else if (psel && penable && pwrite && pready && paddr == dtt_pkg::WindowAddr) begin
      rollover_window_ms <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == dtt_pkg::WindowAddr) ? rollover_window_ms : '0;

  dtt_control u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  dtt_datapath u_dp (
    .clk, .rst, .cmd, .stat, .op, .now_ms, .target_slot, .period_ms,
    .repeats, .restart_now, .window(rollover_window_ms),
    .status, .slot_index, .wait_ms, .front_alert, .last_result
  );

endmodule

// ===== test/deadline_timer_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deadline timer table testbench
// Drives add, cancel, refresh, reset, query and collect requests through the
// valid/stall request channel, predicts every result with a behavioural
// model of the timer table held here, and checks each result in order.
// Runs a directed part, rollover window settings, then random phases with
// varied sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module deadline_timer_table_test;

  // Op codes that the block does not define; they must leave the table alone.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int         DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  st;
    logic [3:0]  slot;
    logic [63:0] wait_ms;
    logic        alert;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  op;
  logic [63:0] now_ms;
  logic [3:0]  target_slot;
  logic [31:0] period_ms;
  logic        repeats;
  logic        restart_now;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [3:0]  slot_index;
  logic [63:0] wait_ms;
  logic        front_alert;
  logic        last_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  deadline_timer_table dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the timer table.
  logic [63:0] deadline_tab [dtt_pkg::TimerSlots];
  logic [31:0] period_tab   [dtt_pkg::TimerSlots];
  logic        repeat_tab   [dtt_pkg::TimerSlots];
  logic        live_tab     [dtt_pkg::TimerSlots];
  bit          written_tab  [dtt_pkg::TimerSlots];
  logic        front_seen;
  logic [63:0] last_collect_time;
  logic [31:0] window_ms;

  timer_result_t pending_results [$];
  int            mismatches;
  int            send_idle_pct;
  int            stall_pct;
  logic [63:0]   clock_ms;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? dtt_pkg::AllOnes : s[63:0];
  endfunction

  function automatic bit precedes(int a, logic [63:0] da, int b, logic [63:0] db);
    return (da < db) || (da == db && a < b);
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < dtt_pkg::TimerSlots; i++)
      if (live_tab[i] && (best < 0 || precedes(i, deadline_tab[i], best, deadline_tab[best])))
        best = i;
    return best;
  endfunction

  // Raises the alert once when a freshly placed timer lands at the front.
  function automatic logic front_check(int s);
    if (earliest_slot() == s && !front_seen) begin
      front_seen = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_result(logic [1:0] st, int slot, logic [63:0] w,
                                      logic alert, logic last);
    timer_result_t r;
    r.st = st;
    r.slot = slot[3:0];
    r.wait_ms = w;
    r.alert = alert;
    r.last = last;
    pending_results = {pending_results, r};
  endfunction

  // Works out the results of one accepted request and updates the shadow table.
  function automatic void predict_request(logic [2:0] code, logic [63:0] now, logic [3:0] tgt,
                                          logic [31:0] per, logic rep, logic fnow);
    int          f, e, n, b;
    bit          roll;
    bit          due [dtt_pkg::TimerSlots];
    int          order [$];
    logic [63:0] start;
    f = -1;
    case (code)
      dtt_pkg::OP_ADD: begin
        for (int i = dtt_pkg::TimerSlots - 1; i >= 0; i--)
          if (!live_tab[i]) f = i;
        if (f < 0) begin
          push_result(dtt_pkg::ST_FULL, 0, '0, 1'b0, 1'b1);
        end else begin
          deadline_tab[f] = sat_sum(now, {32'd0, per});
          period_tab[f] = per;
          repeat_tab[f] = rep;
          live_tab[f] = 1'b1;
          written_tab[f] = 1'b1;
          push_result(dtt_pkg::ST_OK, f, '0, front_check(f), 1'b1);
        end
      end
      dtt_pkg::OP_CANCEL: begin
        if (!live_tab[tgt]) begin
          push_result(dtt_pkg::ST_INACTIVE, int'(tgt), '0, 1'b0, 1'b1);
        end else begin
          live_tab[tgt] = 1'b0;
          push_result(dtt_pkg::ST_OK, int'(tgt), '0, 1'b0, 1'b1);
        end
      end
      dtt_pkg::OP_REFRESH: begin
        if (!live_tab[tgt]) begin
          push_result(dtt_pkg::ST_INACTIVE, int'(tgt), '0, 1'b0, 1'b1);
        end else begin
          deadline_tab[tgt] = sat_sum(now, {32'd0, period_tab[tgt]});
          push_result(dtt_pkg::ST_OK, int'(tgt), '0, 1'b0, 1'b1);
        end
      end
      dtt_pkg::OP_RESET: begin
        if (per == period_tab[tgt] && !fnow) begin
          push_result(dtt_pkg::ST_OK, int'(tgt), '0, 1'b0, 1'b1);
        end else if (!live_tab[tgt]) begin
          push_result(dtt_pkg::ST_INACTIVE, int'(tgt), '0, 1'b0, 1'b1);
        end else begin
          start = fnow ? now : deadline_tab[tgt] - {32'd0, period_tab[tgt]};
          period_tab[tgt] = per;
          deadline_tab[tgt] = sat_sum(start, {32'd0, per});
          push_result(dtt_pkg::ST_OK, int'(tgt), '0, front_check(int'(tgt)), 1'b1);
        end
      end
      dtt_pkg::OP_QUERY: begin
        front_seen = 1'b0;
        e = earliest_slot();
        if (e < 0) push_result(dtt_pkg::ST_OK, 0, dtt_pkg::AllOnes, 1'b0, 1'b1);
        else if (now >= deadline_tab[e]) push_result(dtt_pkg::ST_OK, 0, '0, 1'b0, 1'b1);
        else push_result(dtt_pkg::ST_OK, 0, deadline_tab[e] - now, 1'b0, 1'b1);
      end
      dtt_pkg::OP_COLLECT: begin
        e = earliest_slot();
        if (e < 0) begin
          push_result(dtt_pkg::ST_NONE, 0, '0, 1'b0, 1'b1);
        end else begin
          roll = (now < last_collect_time) &&
                 (last_collect_time - now > {32'd0, window_ms});
          last_collect_time = now;
          if (!roll && deadline_tab[e] > now) begin
            push_result(dtt_pkg::ST_NONE, 0, '0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < dtt_pkg::TimerSlots; i++)
              due[i] = live_tab[i] && (roll || deadline_tab[i] <= now);
            // Expired slots go out in deadline order, lower slot first on ties.
            forever begin
              b = -1;
              for (int i = 0; i < dtt_pkg::TimerSlots; i++)
                if (due[i] && (b < 0 || precedes(i, deadline_tab[i], b, deadline_tab[b])))
                  b = i;
              if (b < 0) break;
              due[b] = 0;
              order = {order, b};
            end
            n = order.size();
            for (int k = 0; k < n; k++) begin
              if (repeat_tab[order[k]])
                deadline_tab[order[k]] = sat_sum(now, {32'd0, period_tab[order[k]]});
              else
                live_tab[order[k]] = 1'b0;
              push_result(dtt_pkg::ST_OK, order[k], '0, 1'b0, k == n - 1);
            end
          end
        end
      end
      default: push_result(dtt_pkg::ST_OK, 0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    timer_result_t seen, want;
    if (!rst && out_valid && !out_stall) begin
      seen = '{status, slot_index, wait_ms, front_alert, last_result};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d slot=%0d wait=%0h alert=%0b last=%0b",
                   status, slot_index, wait_ms, front_alert, last_result);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d slot=%0d wait=%0h alert=%0b last=%0b, %s",
                     want.st, want.slot, want.wait_ms, want.alert, want.last,
                     $sformatf("got st=%0d slot=%0d wait=%0h alert=%0b last=%0b",
                               status, slot_index, wait_ms, front_alert, last_result));
        end
      end
    end
  end

  // The receiver stalls at random, at the rate the current phase sets.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Sends one request and returns at the edge that accepts it.
  task automatic send_request(logic [2:0] code, logic [63:0] now, logic [3:0] tgt,
                              logic [31:0] per, logic rep, logic fnow);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    // A reset of a slot never written must not compare against an unset period.
    if (code == dtt_pkg::OP_RESET && !written_tab[tgt]) fnow = 1'b1;
    op <= code;
    now_ms <= now;
    target_slot <= tgt;
    period_ms <= per;
    repeats <= rep;
    restart_now <= fnow;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_request(code, now, tgt, per, rep, fnow);
  endtask

  // Lets all expected results arrive, then gives the block time to settle.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(logic [31:0] value);
    drain_block();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= dtt_pkg::WindowAddr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    window_ms = value;
  endtask

  task automatic test_directed();
    logic [63:0] t;
    t = 64'd1000;
    // Empty table reads all ones, collect on an empty table, then free-slot requests.
    send_request(dtt_pkg::OP_QUERY, t, 4'd0, 32'd0, 1'b0, 1'b0);
    send_request(dtt_pkg::OP_COLLECT, t, 4'd0, 32'd0, 1'b0, 1'b0);
    send_request(dtt_pkg::OP_CANCEL, t, 4'd15, 32'd0, 1'b0, 1'b0);
    send_request(dtt_pkg::OP_REFRESH, t, 4'd3, 32'd0, 1'b0, 1'b0);
    send_request(dtt_pkg::OP_RESET, t, 4'd7, 32'd5, 1'b0, 1'b1);
    // The first timer takes the front; the earlier second one finds the flag set.
    send_request(dtt_pkg::OP_ADD, t, 4'd0, 32'd50, 1'b1, 1'b0);
    send_request(dtt_pkg::OP_ADD, t, 4'd0, 32'd0, 1'b0, 1'b0);
    send_request(dtt_pkg::OP_QUERY, t, 4'd0, 32'd0, 1'b0, 1'b0);   // overdue: zero wait
    send_request(dtt_pkg::OP_ADD, t, 4'd0, 32'd0, 1'b0, 1'b0);     // ties the front, no alert
    send_request(dtt_pkg::OP_ADD, dtt_pkg::AllOnes, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_request(dtt_pkg::OP_RESET, t, 4'd0, 32'd50, 1'b0, 1'b0);  // unchanged period
    send_request(dtt_pkg::OP_RESET, t, 4'd0, 32'd20, 1'b0, 1'b0);  // from old start
    send_request(dtt_pkg::OP_REFRESH, t + 64'd5, 4'd1, 32'd0, 1'b0, 1'b0);
    send_request(dtt_pkg::OP_COLLECT, t + 64'd5, 4'd0, 32'd0, 1'b0, 1'b0); // two expire
    send_request(dtt_pkg::OP_COLLECT, t + 64'd6, 4'd0, 32'd0, 1'b0, 1'b0); // nothing due
    for (int i = 0; i < 15; i++)
      send_request(dtt_pkg::OP_ADD, t, 4'd0, 32'(i * 3), i[0], 1'b0);
    send_request(dtt_pkg::OP_ADD, t, 4'd0, 32'd1, 1'b0, 1'b0);     // table full
    send_request(OP_SPARE_LO, t, 4'd2, 32'd9, 1'b1, 1'b1);
    send_request(OP_SPARE_HI, dtt_pkg::AllOnes, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_request(dtt_pkg::OP_COLLECT, t + 64'd100, 4'd0, 32'd0, 1'b0, 1'b0); // many expire
  endtask

  // Backward clock jumps either side of the window, at several window settings.
  task automatic test_rollover();
    logic [31:0] settings [4];
    settings = '{32'd0, 32'hFFFF_FFFF, 32'd1000, dtt_pkg::WindowReset};
    foreach (settings[s]) begin
      write_window(settings[s]);
      clock_ms = 64'd5_000_000;
      send_request(dtt_pkg::OP_ADD, clock_ms, 4'd0, 32'd100000, 1'b1, 1'b0);
      send_request(dtt_pkg::OP_COLLECT, clock_ms, 4'd0, 32'd0, 1'b0, 1'b0);
      send_request(dtt_pkg::OP_COLLECT, clock_ms - 64'd1000, 4'd0, 32'd0, 1'b0, 1'b0);
      send_request(dtt_pkg::OP_COLLECT, clock_ms - 64'd1001, 4'd0, 32'd0, 1'b0, 1'b0);
      send_request(dtt_pkg::OP_COLLECT, 64'd0, 4'd0, 32'd0, 1'b0, 1'b0);
      send_request(dtt_pkg::OP_CANCEL, 64'd0, 4'd0, 32'd0, 1'b0, 1'b0);
    end
  endtask

  // One random request: mostly plausible traffic around a running clock,
  // with occasional wild times, periods and slots.
  task automatic random_request();
    int          pick, live_n;
    logic [3:0]  tgt;
    logic [31:0] per;
    logic [3:0]  live_list [$];
    logic        rep, fnow;
    pick = $urandom_range(99);
    rep = 1'($urandom);
    fnow = 1'($urandom);
    case ($urandom_range(19))
      0: clock_ms = {$urandom, $urandom};
      1: clock_ms = clock_ms - 64'($urandom_range(5_000_000));
      2: clock_ms = clock_ms - 64'($urandom_range(50));
      3: clock_ms = dtt_pkg::AllOnes - 64'($urandom_range(100));
      default: clock_ms = clock_ms + 64'($urandom_range(40));
    endcase
    case ($urandom_range(9))
      0: per = $urandom;
      1: per = 32'hFFFF_FFFF;
      default: per = $urandom_range(60);
    endcase
    for (int i = 0; i < dtt_pkg::TimerSlots; i++)
      if (live_tab[i]) live_list = {live_list, 4'(i)};
    live_n = live_list.size();
    if (live_n > 0 && $urandom_range(9) < 7) tgt = live_list[$urandom_range(live_n - 1)];
    else tgt = 4'($urandom);
    if (pick < 28) send_request(dtt_pkg::OP_ADD, clock_ms, tgt, per, rep, fnow);
    else if (pick < 36) send_request(dtt_pkg::OP_CANCEL, clock_ms, tgt, per, rep, fnow);
    else if (pick < 46) send_request(dtt_pkg::OP_REFRESH, clock_ms, tgt, per, rep, fnow);
    else if (pick < 58) begin
      // Half of the resets keep the period so the no-change case comes up.
      if ($urandom_range(1) && written_tab[tgt]) per = period_tab[tgt];
      send_request(dtt_pkg::OP_RESET, clock_ms, tgt, per, rep, fnow);
    end
    else if (pick < 72) send_request(dtt_pkg::OP_QUERY, clock_ms, tgt, per, rep, fnow);
    else if (pick < 97) send_request(dtt_pkg::OP_COLLECT, clock_ms, tgt, per, rep, fnow);
    else send_request($urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI, clock_ms, tgt, per,
                      rep, fnow);
  endtask

  task automatic test_random(int idle_pct, int stall_rate, logic [31:0] window, int count);
    write_window(window);
    send_idle_pct = idle_pct;
    stall_pct = stall_rate;
    clock_ms = 64'($urandom_range(1000));
    for (int i = 0; i < count; i++) begin
      // Once, halfway through, the sender holds off until the block has fully answered.
      if (i == count / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      random_request();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = dtt_pkg::OP_ADD;
    now_ms = '0;
    target_slot = '0;
    period_ms = '0;
    repeats = 1'b0;
    restart_now = 1'b0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    front_seen = 1'b0;
    last_collect_time = '0;
    window_ms = dtt_pkg::WindowReset;
    clock_ms = '0;
    for (int i = 0; i < dtt_pkg::TimerSlots; i++) begin
      live_tab[i] = 1'b0;
      written_tab[i] = 0;
      period_tab[i] = '0;
      deadline_tab[i] = '0;
      repeat_tab[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_rollover();
    test_random(0, 0, dtt_pkg::WindowReset, 110);
    test_random(83, 0, 32'd0, 100);
    test_random(0, 83, 32'hFFFF_FFFF, 100);
    test_random(16, 16, $urandom, 110);

    drain_block();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
